// ===== hdl/dhte_pkg.sv =====
// Package for the double hash table engine: sizes, status codes, hash multiplier constant.
// No dependencies.
package dhte_pkg;
  localparam int LOG2_CAP = 8;
  localparam int CAP = 1 << LOG2_CAP;
  localparam int KEY_W = 32;
  localparam int HASH_W = 32;
  localparam int CNT_W = LOG2_CAP + 1;
  localparam int IDX_W = LOG2_CAP;
  localparam int FULL_LIMIT = CAP - (CAP >> 5);
  localparam logic [31:0] GOLDEN = 32'h9E3779B9;

  localparam logic [1:0] OP_SEARCH = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_NEW = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_REMOVED = 3'd4;

  typedef struct packed {
    logic [2:0] status;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] live;
  } result_t;
endpackage

// ===== hdl/double_hash_table_engine.sv =====
// Top level of the double hash table engine: sequencer, slot stores, counters.
// Depends on dhte_pkg and dhte_hash.
//
// Channel | Direction | tdata (low bit up)                      | Handshake
// in      | slave     | operation[1:0], key[33:2], zero pad     | in_tvalid/in_tready
// out     | master    | status[2:0], slot_index[10:3], live[19:11], pad | out_tvalid/out_tready
//
// Each item passes S_HASH and S_INIT, then per probed slot one slot store read
// (S_READ) followed by one compare/update step (S_CHECK), then the result transfer.
// After reset a clearing pass frees every slot hash; in_tready stays low
// during it. A stalled result holds and blocks the next item.
module double_hash_table_engine (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [39:0] in_tdata,  // operation[1:0], key[33:2]
  output logic out_tvalid,
  input  logic out_tready,
  output logic [23:0] out_tdata  // status[2:0], slot_index[10:3], live_count[19:11]
);
  import dhte_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_INIT = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [HASH_W-1:0] hash_mem [CAP];
  logic [KEY_W-1:0] key_mem [CAP];

  logic [2:0] state_r, state_nxt;
  logic [1:0] op_r;
  logic [KEY_W-1:0] key_r;
  logic [HASH_W-1:0] h_r;
  logic [IDX_W-1:0] idx_r, step_r, rem_r;
  logic have_rem_r;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] entry_r, removed_r;
  result_t res_r;
  logic [HASH_W-1:0] s_rd_r;
  logic [KEY_W-1:0] k_rd_r;
  logic [HASH_W-1:0] hash_w;
  logic [IDX_W-1:0] clr_r;

  logic wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [HASH_W-1:0] wr_hash;
  logic wr_key;

  dhte_hash u_hash (
    .clk  (clk),
    .start(in_tvalid && in_tready),
    .key  (in_tdata[33:2]),
    .hash (hash_w)
  );

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {4'd0, res_r.live, res_r.slot, res_r.status};

  always_ff @(posedge clk) begin
    s_rd_r <= hash_mem[idx_r];
    k_rd_r <= key_mem[idx_r];
    if (wr_en) begin
      hash_mem[wr_idx] <= wr_hash;
    end
    if (wr_en && wr_key) begin
      key_mem[wr_idx] <= key_r;
    end
  end

  logic live_match;
  logic is_add;
  logic full_now;
  assign is_add = (op_r == OP_ADD);
  assign live_match = (s_rd_r > 32'd1) && ({s_rd_r[31:1], 1'b0} == h_r) && (k_rd_r == key_r);
  assign full_now = ({1'b0, entry_r} + {1'b0, removed_r}) >= (CNT_W+1)'(FULL_LIMIT);

  always_comb begin
    state_nxt = state_r;
    wr_en = 1'b0;
    wr_idx = idx_r;
    wr_hash = '0;
    wr_key = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_idx = clr_r;
        if (clr_r == IDX_W'(CAP - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_tvalid) state_nxt = S_HASH;
      S_HASH: state_nxt = S_INIT;
      S_INIT: state_nxt = (is_add && full_now) ? S_OUT : S_READ;
      S_READ: state_nxt = S_CHECK;
      S_CHECK: begin
        state_nxt = S_READ;
        if (s_rd_r == 32'd0) begin
          state_nxt = S_OUT;
          if (is_add) begin
            wr_en = 1'b1;
            wr_idx = have_rem_r ? rem_r : idx_r;
            wr_hash = have_rem_r ? (h_r | 32'd1) : h_r;
            wr_key = 1'b1;
          end
        end else if (live_match) begin
          state_nxt = S_OUT;
          if (op_r == OP_REMOVE) begin
            wr_en = 1'b1;
            wr_hash = s_rd_r[0] ? 32'd1 : 32'd0;
          end
        end else begin
          if (is_add && s_rd_r != 32'd1) begin
            wr_en = 1'b1;
            wr_hash = s_rd_r | 32'd1;
          end
          if (n_r == CNT_W'(CAP - 1)) begin
            state_nxt = S_OUT;
            if (is_add && have_rem_r) begin
              wr_en = 1'b1;
              wr_idx = rem_r;
              wr_hash = h_r | 32'd1;
              wr_key = 1'b1;
            end
          end
        end
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      entry_r <= '0;
      removed_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == S_CHECK && wr_en && wr_key) begin
        entry_r <= entry_r + 1'b1;
        if (have_rem_r) removed_r <= removed_r - 1'b1;
      end
      if (state_r == S_CHECK && live_match && op_r == OP_REMOVE) begin
        entry_r <= entry_r - 1'b1;
        if (s_rd_r[0]) removed_r <= removed_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        op_r <= in_tdata[1:0];
        key_r <= in_tdata[33:2];
      end
      S_HASH: ;
      S_INIT: begin
        h_r <= hash_w;
        idx_r <= hash_w[HASH_W-1 -: IDX_W];
        step_r <= {hash_w[HASH_W-1-IDX_W -: IDX_W-1], 1'b1};
        have_rem_r <= 1'b0;
        rem_r <= '0;
        n_r <= '0;
        res_r.status <= ST_FULL;
        res_r.slot <= '0;
        res_r.live <= entry_r;
      end
      S_CHECK: begin
        if (s_rd_r == 32'd0) begin
          res_r.status <= is_add ? ST_NEW : ST_MISS;
          res_r.slot <= is_add ? (have_rem_r ? rem_r : idx_r) : '0;
          res_r.live <= is_add ? entry_r + 1'b1 : entry_r;
        end else if (live_match) begin
          res_r.status <= (op_r == OP_REMOVE) ? ST_REMOVED : ST_HIT;
          res_r.slot <= idx_r;
          res_r.live <= (op_r == OP_REMOVE) ? entry_r - 1'b1 : entry_r;
        end else begin
          if (is_add && s_rd_r == 32'd1 && !have_rem_r) begin
            have_rem_r <= 1'b1;
            rem_r <= idx_r;
          end
          idx_r <= idx_r - step_r;
          n_r <= n_r + 1'b1;
          if (n_r == CNT_W'(CAP - 1)) begin
            if (is_add && have_rem_r) begin
              res_r.status <= ST_NEW;
              res_r.slot <= rem_r;
              res_r.live <= entry_r + 1'b1;
            end else begin
              res_r.status <= is_add ? ST_FULL : ST_MISS;
              res_r.slot <= '0;
              res_r.live <= entry_r;
            end
          end
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== hdl/dhte_hash.sv =====
// Key hash unit: registered golden-ratio multiply then combinational fixup.
// Depends on dhte_pkg.
module dhte_hash (
  input  logic clk,
  input  logic start,
  input  logic [dhte_pkg::KEY_W-1:0] key,
  output logic [dhte_pkg::HASH_W-1:0] hash
);
  import dhte_pkg::*;
  logic [31:0] prod_r;
  logic [31:0] fix;
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= 32'(key >> 2) * GOLDEN;
    end
  end
  always_comb begin
    fix = (prod_r < 32'd2) ? prod_r - 32'd2 : prod_r;
    hash = {fix[31:1], 1'b0};
  end
endmodule
